>>> src/dmwbc_pkg.sv
// Shared constants, codes and control structs for the direct-mapped write-back cache.
`default_nettype none
package dmwbc_pkg;

    localparam int ADDR_W     = 8;
    localparam int WORD_W     = 32;
    localparam int CALLER_W   = 2;
    localparam int DELAY_W    = 8;
    localparam int COUNT_W    = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int MEMOP_W    = 2;

    localparam int LINE_COUNT = 16;
    localparam int LINE_WORDS = 4;
    localparam int OFF_W      = $clog2(LINE_WORDS);
    localparam int LINE_NUM_W = ADDR_W - OFF_W;
    localparam int IDX_W      = $clog2(LINE_COUNT);
    localparam int TAG_W      = (LINE_NUM_W > IDX_W) ? (LINE_NUM_W - IDX_W) : 1;
    localparam int DATA_DEPTH = LINE_COUNT * LINE_WORDS;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STORE = 2'd1,
        CMD_INVAL = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RETRY     = 2'd0,
        ST_DONE      = 2'd1,
        ST_WRITEBACK = 2'd2
    } status_t;

    typedef enum logic [MEMOP_W-1:0] {
        MEM_NONE  = 2'd0,
        MEM_FETCH = 2'd1,
        MEM_WRITE = 2'd2
    } mem_op_t;

    typedef enum logic [2:0] {
        RES_RETRY       = 3'd0,
        RES_RETRY_FETCH = 3'd1,
        RES_RETRY_WRITE = 3'd2,
        RES_DONE        = 3'd3,
        RES_LOAD_HIT    = 3'd4,
        RES_WB          = 3'd5,
        RES_FILL_DONE   = 3'd6,
        RES_WRITE_DONE  = 3'd7
    } res_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HIT,
        S_WB_RD,
        S_WB_PUT,
        S_FILL,
        S_FILL_RD,
        S_FILL_DONE
    } state_t;

    typedef struct packed {
        logic      req_ready;
        logic      capture;
        logic      lock_take;
        logic      wait_dec;
        logic      release_lock;
        logic      inval;
        logic      word_sel;
        logic      ram_we;
        logic      we_fill;
        logic      wcnt_clr;
        logic      wcnt_inc;
        logic      install;
        logic      set_dirty;
        logic      out_load;
        res_kind_t out_kind;
    } dmwbc_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic req_valid;
        logic not_owner;
        logic wait_pending;
        logic hit;
        logic victim_dirty;
        logic mem_ready;
        logic wcnt_last;
        logic out_free;
    } dmwbc_stat_t;

endpackage
`default_nettype wire

>>> src/dmwbc_req_if.sv
// Request channel: command word with fill words from memory.
`default_nettype none
interface dmwbc_req_if;
    import dmwbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   wdata;
    logic [CALLER_W-1:0] caller;
    logic                mem_ready;
    logic [WORD_W-1:0]   fill_word0;
    logic [WORD_W-1:0]   fill_word1;
    logic [WORD_W-1:0]   fill_word2;
    logic [WORD_W-1:0]   fill_word3;

    modport source (
        output valid, cmd, addr, wdata, caller, mem_ready,
               fill_word0, fill_word1, fill_word2, fill_word3,
        input  ready
    );

    modport sink (
        input  valid, cmd, addr, wdata, caller, mem_ready,
               fill_word0, fill_word1, fill_word2, fill_word3,
        output ready
    );
endinterface
`default_nettype wire

>>> src/dmwbc_rsp_if.sv
// Response channel: result word with memory request fields.
`default_nettype none
interface dmwbc_rsp_if;
    import dmwbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   rdata;
    logic [MEMOP_W-1:0]  mem_op;
    logic [ADDR_W-1:0]   mem_addr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [COUNT_W-1:0]  miss_total;
    logic                last;

    modport source (
        output valid, status, rdata, mem_op, mem_addr, mem_wdata, miss_total, last,
        input  ready
    );

    modport sink (
        input  valid, status, rdata, mem_op, mem_addr, mem_wdata, miss_total, last,
        output ready
    );
endinterface
`default_nettype wire

>>> src/direct_mapped_writeback_cache.sv
// Top level of the direct-mapped write-back cache with caller lock.
//
//   channel  | dir | handshake          | word
//   ---------+-----+--------------------+---------------------------------------
//   req      | in  | valid/ready        | cmd, addr, wdata, caller, mem_ready, fill
//   rsp      | out | valid/ready        | status, rdata, mem_op, mem_addr, ...
//   cfg      | in  | cfg_we, no wait    | access_delay
//
// One request word at a time. Retry, store, invalidate: S_DECIDE; load hit: S_HIT;
// line fill: S_FILL, S_FILL_RD, S_FILL_DONE; dirty victim: S_WB_RD/S_WB_PUT first.
// The word-wide data RAM moves one word per cycle and has a registered read port,
// which sets the writeback and fill lengths. Stalls on rsp hold the sequencer
// before each result load. Reset clears valid/dirty bits, lock and counters.
`default_nettype none
module direct_mapped_writeback_cache (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dmwbc_req_if.sink                          req,
    dmwbc_rsp_if.source                        rsp,
    input  wire logic                          cfg_we,
    input  wire logic [dmwbc_pkg::DELAY_W-1:0] cfg_wdata
);
    import dmwbc_pkg::*;

    dmwbc_cmd_t  ctl_cmd;
    dmwbc_stat_t dp_stat;

    dmwbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (dp_stat),
        .cmd   (ctl_cmd)
    );

    dmwbc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .req       (req),
        .rsp       (rsp)
    );

    a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.status == ST_WRITEBACK) == !rsp.last))
        else $error("writeback status and last flag disagree");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.out_load |-> dp_stat.out_free)
        else $error("result loaded over a pending word");

    a_store_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.ram_we && !ctl_cmd.we_fill) |-> (dp_stat.hit && (dp_stat.cmd == CMD_STORE)))
        else $error("store written into a line that missed");

    a_release_dec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.release_lock |-> !ctl_cmd.wait_dec)
        else $error("lock released while delay still counting");
endmodule
`default_nettype wire

>>> src/dmwbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dmwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> src/dmwbc_ctrl.sv
// Sequencer for lookup, victim writeback, line fill and result issue.
`default_nettype none
module dmwbc_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dmwbc_pkg::dmwbc_stat_t  stat,
    output dmwbc_pkg::dmwbc_cmd_t        cmd
);
    import dmwbc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.req_ready = 1'b1;
                if (stat.req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                    unique case (stat.cmd) inside
                        CMD_INVAL:
                        begin
                            cmd.inval    = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_kind = RES_DONE;
                        end
                        CMD_NOP:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = RES_DONE;
                        end
                        CMD_LOAD, CMD_STORE:
                        begin
                            cmd.lock_take = 1'b1;
                            if (stat.not_owner)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = RES_RETRY;
                            end
                            else if (stat.wait_pending)
                            begin
                                cmd.wait_dec = 1'b1;
                                cmd.out_load = 1'b1;
                                cmd.out_kind = RES_RETRY;
                            end
                            else if (stat.cmd == CMD_LOAD)
                            begin
                                if (stat.hit)
                                begin
                                    cmd.release_lock = 1'b1;
                                    state_next       = S_HIT;
                                end
                                else if (!stat.mem_ready)
                                begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_kind = RES_RETRY_FETCH;
                                end
                                else if (stat.victim_dirty)
                                begin
                                    cmd.wcnt_clr = 1'b1;
                                    state_next   = S_WB_RD;
                                end
                                else
                                begin
                                    cmd.wcnt_clr = 1'b1;
                                    state_next   = S_FILL;
                                end
                            end
                            else if (stat.hit)
                            begin
                                cmd.ram_we       = 1'b1;
                                cmd.set_dirty    = 1'b1;
                                cmd.release_lock = 1'b1;
                                cmd.out_load     = 1'b1;
                                cmd.out_kind     = RES_DONE;
                            end
                            else if (!stat.mem_ready)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = RES_RETRY_WRITE;
                            end
                            else
                            begin
                                cmd.release_lock = 1'b1;
                                cmd.out_load     = 1'b1;
                                cmd.out_kind     = RES_WRITE_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = RES_LOAD_HIT;
                    state_next   = S_IDLE;
                end
            end
            S_WB_RD:
            begin
                cmd.word_sel = 1'b1;
                state_next   = S_WB_PUT;
            end
            S_WB_PUT:
            begin
                cmd.word_sel = 1'b1;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = RES_WB;
                    if (stat.wcnt_last)
                    begin
                        cmd.wcnt_clr = 1'b1;
                        state_next   = S_FILL;
                    end
                    else
                    begin
                        cmd.wcnt_inc = 1'b1;
                        state_next   = S_WB_RD;
                    end
                end
            end
            S_FILL:
            begin
                cmd.word_sel = 1'b1;
                cmd.ram_we   = 1'b1;
                cmd.we_fill  = 1'b1;
                cmd.wcnt_inc = 1'b1;
                if (stat.wcnt_last)
                begin
                    state_next = S_FILL_RD;
                end
            end
            S_FILL_RD:
            begin
                state_next = S_FILL_DONE;
            end
            S_FILL_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.install      = 1'b1;
                    cmd.release_lock = 1'b1;
                    cmd.out_load     = 1'b1;
                    cmd.out_kind     = RES_FILL_DONE;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> src/dmwbc_dpath.sv
// Datapath: request latch, line state, lock, data RAM and result register.
`default_nettype none
module dmwbc_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dmwbc_pkg::DELAY_W-1:0] cfg_wdata,
    input  wire dmwbc_pkg::dmwbc_cmd_t         cmd,
    output dmwbc_pkg::dmwbc_stat_t             stat,
    dmwbc_req_if.sink                          req,
    dmwbc_rsp_if.source                        rsp
);
    import dmwbc_pkg::*;

    // request latch
    cmd_t                cmd_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [WORD_W-1:0]   wdata_reg;
    logic [CALLER_W-1:0] caller_reg;
    logic                mem_ready_reg;
    logic [WORD_W-1:0]   fill_reg [LINE_WORDS];

    // line state
    logic [TAG_W-1:0]      tag_mem_reg [LINE_COUNT];
    logic [LINE_COUNT-1:0] valid_reg;
    logic [LINE_COUNT-1:0] valid_next;
    logic [LINE_COUNT-1:0] dirty_reg;
    logic [LINE_COUNT-1:0] dirty_next;

    // lock and counters
    logic [DELAY_W-1:0]  delay_reg;
    logic [DELAY_W-1:0]  delay_next;
    logic [DELAY_W-1:0]  wait_reg;
    logic [DELAY_W-1:0]  wait_next;
    logic                owner_held_reg;
    logic                owner_held_next;
    logic [CALLER_W-1:0] owner_id_reg;
    logic [CALLER_W-1:0] owner_id_next;
    logic [COUNT_W-1:0]  fill_count_reg;
    logic [COUNT_W-1:0]  fill_count_next;
    logic [OFF_W-1:0]    wcnt_reg;
    logic [OFF_W-1:0]    wcnt_next;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [WORD_W-1:0]  rdata_reg;
    logic [WORD_W-1:0]  rdata_next;
    mem_op_t            mem_op_reg;
    mem_op_t            mem_op_next;
    logic [ADDR_W-1:0]  mem_addr_reg;
    logic [ADDR_W-1:0]  mem_addr_next;
    logic [WORD_W-1:0]  mem_wdata_reg;
    logic [WORD_W-1:0]  mem_wdata_next;
    logic [COUNT_W-1:0] miss_total_reg;
    logic               last_reg;

    logic [LINE_NUM_W-1:0]  blk_num;
    logic [IDX_W-1:0]       idx;
    logic [TAG_W-1:0]       tag;
    logic [OFF_W-1:0]       off;
    logic [ADDR_W-1:0]      base;
    logic [ADDR_W-1:0]      victim_addr;
    logic [OFF_W-1:0]       word;
    logic [IDX_W+OFF_W-1:0] ram_addr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;

    assign blk_num     = addr_reg[ADDR_W-1:OFF_W];
    assign idx         = blk_num[IDX_W-1:0];
    assign tag         = TAG_W'(blk_num >> IDX_W);
    assign off         = addr_reg[OFF_W-1:0];
    assign base        = {blk_num, OFF_W'(0)};
    assign victim_addr = ADDR_W'({tag_mem_reg[idx], idx, wcnt_reg});
    assign word        = cmd.word_sel ? wcnt_reg : off;
    assign ram_addr    = {idx, word};
    assign ram_wdata   = cmd.we_fill ? fill_reg[0] : wdata_reg;

    dmwbc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign req.ready = cmd.req_ready;

    assign stat.cmd          = cmd_reg;
    assign stat.req_valid    = req.valid;
    assign stat.not_owner    = owner_held_reg && (caller_reg != owner_id_reg);
    assign stat.wait_pending = (wait_reg != '0);
    assign stat.hit          = valid_reg[idx] && (tag_mem_reg[idx] == tag);
    assign stat.victim_dirty = valid_reg[idx] && dirty_reg[idx];
    assign stat.mem_ready    = mem_ready_reg;
    assign stat.wcnt_last    = (wcnt_reg == OFF_W'(LINE_WORDS - 1));
    assign stat.out_free     = !out_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        if (cmd.inval)
        begin
            valid_next = '0;
            dirty_next = '0;
        end
        if (cmd.install)
        begin
            valid_next[idx] = 1'b1;
            dirty_next[idx] = 1'b0;
        end
        if (cmd.set_dirty)
        begin
            dirty_next[idx] = 1'b1;
        end
    end

    always_comb
    begin
        delay_next      = delay_reg;
        wait_next       = wait_reg;
        owner_held_next = owner_held_reg;
        owner_id_next   = owner_id_reg;
        if (cmd.release_lock)
        begin
            owner_held_next = 1'b0;
            owner_id_next   = '0;
            wait_next       = delay_reg;
        end
        else
        begin
            if (cmd.lock_take && !owner_held_reg)
            begin
                owner_held_next = 1'b1;
                owner_id_next   = caller_reg;
            end
            if (cmd.wait_dec)
            begin
                wait_next = wait_reg - DELAY_W'(1);
            end
        end
        if (cfg_we)
        begin
            delay_next = cfg_wdata;
            wait_next  = cfg_wdata;
        end
    end

    assign fill_count_next = cmd.install ? (fill_count_reg + COUNT_W'(1)) : fill_count_reg;

    always_comb
    begin
        wcnt_next = wcnt_reg;
        if (cmd.wcnt_clr)
        begin
            wcnt_next = '0;
        end
        else if (cmd.wcnt_inc)
        begin
            wcnt_next = wcnt_reg + OFF_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        status_next    = ST_RETRY;
        rdata_next     = '0;
        mem_op_next    = MEM_NONE;
        mem_addr_next  = '0;
        mem_wdata_next = '0;
        case (cmd.out_kind)
            RES_RETRY:
            begin
                status_next = ST_RETRY;
            end
            RES_RETRY_FETCH:
            begin
                mem_op_next   = MEM_FETCH;
                mem_addr_next = base;
            end
            RES_RETRY_WRITE:
            begin
                mem_op_next    = MEM_WRITE;
                mem_addr_next  = addr_reg;
                mem_wdata_next = wdata_reg;
            end
            RES_DONE:
            begin
                status_next = ST_DONE;
            end
            RES_LOAD_HIT:
            begin
                status_next = ST_DONE;
                rdata_next  = ram_rdata;
            end
            RES_WB:
            begin
                status_next    = ST_WRITEBACK;
                mem_op_next    = MEM_WRITE;
                mem_addr_next  = victim_addr;
                mem_wdata_next = ram_rdata;
            end
            RES_FILL_DONE:
            begin
                status_next   = ST_DONE;
                rdata_next    = ram_rdata;
                mem_op_next   = MEM_FETCH;
                mem_addr_next = base;
            end
            RES_WRITE_DONE:
            begin
                status_next    = ST_DONE;
                mem_op_next    = MEM_WRITE;
                mem_addr_next  = addr_reg;
                mem_wdata_next = wdata_reg;
            end
            default:
            begin
                status_next = ST_RETRY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            dirty_reg      <= '0;
            delay_reg      <= '0;
            wait_reg       <= '0;
            owner_held_reg <= 1'b0;
            owner_id_reg   <= '0;
            fill_count_reg <= '0;
            wcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            dirty_reg      <= dirty_next;
            delay_reg      <= delay_next;
            wait_reg       <= wait_next;
            owner_held_reg <= owner_held_next;
            owner_id_reg   <= owner_id_next;
            fill_count_reg <= fill_count_next;
            wcnt_reg       <= wcnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg       <= cmd_t'(req.cmd);
            addr_reg      <= req.addr;
            wdata_reg     <= req.wdata;
            caller_reg    <= req.caller;
            mem_ready_reg <= req.mem_ready;
            fill_reg[0]   <= req.fill_word0;
            fill_reg[1]   <= req.fill_word1;
            fill_reg[2]   <= req.fill_word2;
            fill_reg[3]   <= req.fill_word3;
        end
        else if (cmd.we_fill)
        begin
            // advance the fill words toward the write port
            for (int i = 0; i < LINE_WORDS - 1; i++)
            begin
                fill_reg[i] <= fill_reg[i+1];
            end
        end
        if (cmd.install)
        begin
            tag_mem_reg[idx] <= tag;
        end
        if (cmd.out_load)
        begin
            status_reg     <= status_next;
            rdata_reg      <= rdata_next;
            mem_op_reg     <= mem_op_next;
            mem_addr_reg   <= mem_addr_next;
            mem_wdata_reg  <= mem_wdata_next;
            miss_total_reg <= fill_count_next;
            last_reg       <= (cmd.out_kind != RES_WB);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.rdata      = rdata_reg;
    assign rsp.mem_op     = mem_op_reg;
    assign rsp.mem_addr   = mem_addr_reg;
    assign rsp.mem_wdata  = mem_wdata_reg;
    assign rsp.miss_total = miss_total_reg;
    assign rsp.last       = last_reg;
endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the direct-mapped write-back cache: directed rows, then random phases.
module tb_top;
    import dmwbc_pkg::*;

    localparam int LIMIT  = 500000;
    localparam int SETTLE = 24;

    typedef struct packed {
        cmd_t                               cmd;
        logic [ADDR_W-1:0]                  addr;
        logic [WORD_W-1:0]                  wdata;
        logic [CALLER_W-1:0]                caller;
        logic                               mem_ready;
        logic [LINE_WORDS-1:0][WORD_W-1:0]  fill;
    } req_word_t;

    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   rdata;
        mem_op_t             mem_op;
        logic [ADDR_W-1:0]   mem_addr;
        logic [WORD_W-1:0]   mem_wdata;
        logic [COUNT_W-1:0]  miss_total;
        logic                last;
    } rsp_word_t;

    typedef struct packed {
        req_word_t  w;
        logic       typed;
        rsp_word_t  want;
    } plan_row_t;

    localparam rsp_word_t PREDICT = '0;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [DELAY_W-1:0]  cfg_wdata;

    dmwbc_req_if req_ch();
    dmwbc_rsp_if rsp_ch();

    direct_mapped_writeback_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [TAG_W-1:0]    m_tag   [LINE_COUNT];
    logic                m_valid [LINE_COUNT];
    logic                m_dirty [LINE_COUNT];
    logic [WORD_W-1:0]   m_data  [DATA_DEPTH];
    logic [DELAY_W-1:0]  m_delay;
    logic [DELAY_W-1:0]  m_wait;
    logic                lock_held;
    logic [CALLER_W-1:0] lock_id;
    logic [COUNT_W-1:0]  fill_total;

    rsp_word_t   step_rsp [$];
    rsp_word_t   due_rsp  [$];
    rsp_word_t   want_rsp;
    plan_row_t   plan     [$];
    req_word_t   pend;
    bit          pend_ok;
    bit          steady;
    int          fails;
    int          words_sent;
    int          results_seen;
    int          victims_seen;
    int unsigned cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, due_rsp.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_fail(string msg);
        $display("mismatch: %s", msg);
        fails++;
    endtask

    function automatic rsp_word_t result_word(status_t st, logic [WORD_W-1:0] rd, mem_op_t op,
                                              logic [ADDR_W-1:0] ma, logic [WORD_W-1:0] wd,
                                              logic lst);
        rsp_word_t r;
        r.status     = st;
        r.rdata      = rd;
        r.mem_op     = op;
        r.mem_addr   = ma;
        r.mem_wdata  = wd;
        r.miss_total = fill_total;
        r.last       = lst;
        return r;
    endfunction

    task automatic clear_lines();
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            m_tag[i]   = '0;
            m_valid[i] = 1'b0;
            m_dirty[i] = 1'b0;
        end
        for (int i = 0; i < DATA_DEPTH; i++)
            m_data[i] = '0;
    endtask

    task automatic release_lock();
        lock_held = 1'b0;
        lock_id   = '0;
        m_wait    = m_delay;
    endtask

    task automatic advance_cache(input req_word_t w);
        int                 idx;
        int                 off;
        int                 vbase;
        logic [TAG_W-1:0]   tag;
        logic [ADDR_W-1:0]  base;
        logic               hit;
        step_rsp.delete();
        idx  = w.addr[OFF_W +: IDX_W];
        off  = w.addr[OFF_W-1:0];
        tag  = w.addr[ADDR_W-1 -: TAG_W];
        base = {w.addr[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
        if (w.cmd == CMD_INVAL)
        begin
            clear_lines();
            step_rsp.push_back(result_word(ST_DONE, '0, MEM_NONE, '0, '0, 1'b1));
            return;
        end
        if (w.cmd == CMD_NOP)
        begin
            step_rsp.push_back(result_word(ST_DONE, '0, MEM_NONE, '0, '0, 1'b1));
            return;
        end
        if (!lock_held)
        begin
            lock_held = 1'b1;
            lock_id   = w.caller;
        end
        if (w.caller != lock_id)
        begin
            step_rsp.push_back(result_word(ST_RETRY, '0, MEM_NONE, '0, '0, 1'b1));
            return;
        end
        if (m_wait != 0)
        begin
            m_wait = m_wait - DELAY_W'(1);
            step_rsp.push_back(result_word(ST_RETRY, '0, MEM_NONE, '0, '0, 1'b1));
            return;
        end
        hit = m_valid[idx] && (m_tag[idx] == tag);
        if (w.cmd == CMD_LOAD)
        begin
            if (hit)
            begin
                release_lock();
                step_rsp.push_back(result_word(ST_DONE, m_data[idx*LINE_WORDS + off], MEM_NONE,
                                               '0, '0, 1'b1));
                return;
            end
            if (!w.mem_ready)
            begin
                step_rsp.push_back(result_word(ST_RETRY, '0, MEM_FETCH, base, '0, 1'b1));
                return;
            end
            if (m_valid[idx] && m_dirty[idx])
            begin
                vbase = (int'(m_tag[idx]) * LINE_COUNT + idx) * LINE_WORDS;
                for (int i = 0; i < LINE_WORDS; i++)
                    step_rsp.push_back(result_word(ST_WRITEBACK, '0, MEM_WRITE, ADDR_W'(vbase + i),
                                                   m_data[idx*LINE_WORDS + i], 1'b0));
                victims_seen++;
            end
            m_tag[idx] = tag;
            for (int i = 0; i < LINE_WORDS; i++)
                m_data[idx*LINE_WORDS + i] = w.fill[i];
            m_dirty[idx] = 1'b0;
            m_valid[idx] = 1'b1;
            fill_total   = fill_total + COUNT_W'(1);
            release_lock();
            step_rsp.push_back(result_word(ST_DONE, m_data[idx*LINE_WORDS + off], MEM_FETCH,
                                           base, '0, 1'b1));
            return;
        end
        if (hit)
        begin
            m_data[idx*LINE_WORDS + off] = w.wdata;
            m_dirty[idx] = 1'b1;
            release_lock();
            step_rsp.push_back(result_word(ST_DONE, '0, MEM_NONE, '0, '0, 1'b1));
            return;
        end
        if (!w.mem_ready)
        begin
            step_rsp.push_back(result_word(ST_RETRY, '0, MEM_WRITE, w.addr, w.wdata, 1'b1));
            return;
        end
        release_lock();
        step_rsp.push_back(result_word(ST_DONE, '0, MEM_WRITE, w.addr, w.wdata, 1'b1));
    endtask

    function automatic req_word_t word_of(cmd_t c, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] d,
                                          logic [CALLER_W-1:0] who, logic rdy,
                                          logic [LINE_WORDS*WORD_W-1:0] f);
        req_word_t w;
        w.cmd       = c;
        w.addr      = a;
        w.wdata     = d;
        w.caller    = who;
        w.mem_ready = rdy;
        w.fill      = f;
        return w;
    endfunction

    function automatic plan_row_t row(req_word_t w, logic typed = 1'b0, status_t st = ST_RETRY,
                                      logic [WORD_W-1:0] rd = '0, mem_op_t op = MEM_NONE,
                                      logic [ADDR_W-1:0] ma = '0, logic [WORD_W-1:0] wd = '0,
                                      logic [COUNT_W-1:0] miss = '0);
        plan_row_t r;
        r.w                 = w;
        r.typed             = typed;
        r.want.status       = st;
        r.want.rdata        = rd;
        r.want.mem_op       = op;
        r.want.mem_addr     = ma;
        r.want.mem_wdata    = wd;
        r.want.miss_total   = miss;
        r.want.last         = 1'b1;
        return r;
    endfunction

    function automatic req_word_t pick_word();
        req_word_t w;
        int        r;
        w.wdata     = $urandom;
        w.mem_ready = ($urandom_range(0, 99) < 65);
        w.fill      = {$urandom, $urandom, $urandom, $urandom};
        w.caller    = (lock_held && $urandom_range(0, 99) < 85) ? lock_id
                                                                  : CALLER_W'($urandom_range(0, 3));
        if (lock_held && pend_ok && w.caller == lock_id && $urandom_range(0, 99) < 80)
        begin
            w.cmd   = pend.cmd;
            w.addr  = pend.addr;
            w.wdata = pend.wdata;
            return w;
        end
        r = $urandom_range(0, 99);
        w.cmd  = (r < 5) ? CMD_INVAL : (r < 9) ? CMD_NOP : (r < 55) ? CMD_LOAD : CMD_STORE;
        w.addr = {TAG_W'($urandom_range(0, 3)),
                  IDX_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, LINE_COUNT - 1)),
                  OFF_W'($urandom_range(0, LINE_WORDS - 1))};
        return w;
    endfunction

    task automatic send_word(input req_word_t w, input logic typed, input rsp_word_t want);
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= w.cmd;
        req_ch.addr       <= w.addr;
        req_ch.wdata      <= w.wdata;
        req_ch.caller     <= w.caller;
        req_ch.mem_ready  <= w.mem_ready;
        req_ch.fill_word0 <= w.fill[0];
        req_ch.fill_word1 <= w.fill[1];
        req_ch.fill_word2 <= w.fill[2];
        req_ch.fill_word3 <= w.fill[3];
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        advance_cache(w);
        if (typed)
            due_rsp.push_back(want);
        else
            foreach (step_rsp[i])
                due_rsp.push_back(step_rsp[i]);
        words_sent++;
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_delay = v;
        m_wait  = v;
        @(posedge clk);
    endtask

    task automatic run_phase(input int n);
        req_word_t w;
        repeat (n)
        begin
            w = pick_word();
            send_word(w, 1'b0, PREDICT);
            if (!lock_held)
                pend_ok = 1'b0;
            else if (w.caller == lock_id && (w.cmd == CMD_LOAD || w.cmd == CMD_STORE))
            begin
                pend    = w;
                pend_ok = 1'b1;
            end
        end
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!steady)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (due_rsp.size() == 0)
                report_fail($sformatf("result %0d arrived with nothing expected", results_seen));
            else
            begin
                want_rsp = due_rsp.pop_front();
                if (rsp_ch.status !== want_rsp.status)
                    report_fail($sformatf("result %0d status got %0d want %0d",
                                          results_seen, rsp_ch.status, want_rsp.status));
                if (rsp_ch.rdata !== want_rsp.rdata)
                    report_fail($sformatf("result %0d rdata got %h want %h",
                                          results_seen, rsp_ch.rdata, want_rsp.rdata));
                if (rsp_ch.mem_op !== want_rsp.mem_op)
                    report_fail($sformatf("result %0d mem_op got %0d want %0d",
                                          results_seen, rsp_ch.mem_op, want_rsp.mem_op));
                if (rsp_ch.mem_addr !== want_rsp.mem_addr)
                    report_fail($sformatf("result %0d mem_addr got %h want %h",
                                          results_seen, rsp_ch.mem_addr, want_rsp.mem_addr));
                if (rsp_ch.mem_wdata !== want_rsp.mem_wdata)
                    report_fail($sformatf("result %0d mem_wdata got %h want %h",
                                          results_seen, rsp_ch.mem_wdata, want_rsp.mem_wdata));
                if (rsp_ch.miss_total !== want_rsp.miss_total)
                    report_fail($sformatf("result %0d miss_total got %0d want %0d",
                                          results_seen, rsp_ch.miss_total, want_rsp.miss_total));
                if (rsp_ch.last !== want_rsp.last)
                    report_fail($sformatf("result %0d last got %0d want %0d",
                                          results_seen, rsp_ch.last, want_rsp.last));
            end
        end
    end

    initial
    begin
        int phase_delay [6];
        int phase_words [6];
        phase_delay = '{2, 255, 1, 17, 0, 0};
        phase_words = '{30, 100, 25, 25, 25, 25};
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_NOP;
        req_ch.addr       <= '0;
        req_ch.wdata      <= '0;
        req_ch.caller     <= '0;
        req_ch.mem_ready  <= 1'b0;
        req_ch.fill_word0 <= '0;
        req_ch.fill_word1 <= '0;
        req_ch.fill_word2 <= '0;
        req_ch.fill_word3 <= '0;
        fails        = 0;
        words_sent   = 0;
        results_seen = 0;
        victims_seen = 0;
        steady       = 1'b0;
        pend_ok      = 1'b0;
        clear_lines();
        m_delay    = '0;
        m_wait     = '0;
        lock_held  = 1'b0;
        lock_id    = '0;
        fill_total = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_delay(8'd0);

        plan.push_back(row(word_of(CMD_LOAD, 8'h00, 32'h0, 2'd0, 1'b0, '0),
                           1'b1, ST_RETRY, 32'h0, MEM_FETCH, 8'h00, 32'h0, 32'd0));
        plan.push_back(row(word_of(CMD_LOAD, 8'h00, 32'h0, 2'd1, 1'b1, '0),
                           1'b1, ST_RETRY, 32'h0, MEM_NONE, 8'h00, 32'h0, 32'd0));
        plan.push_back(row(word_of(CMD_LOAD, 8'h03, 32'h0, 2'd0, 1'b1,
                                   {32'hFFFF_FFFF, 32'h2222_2222, 32'h1111_1111, 32'h0}),
                           1'b1, ST_DONE, 32'hFFFF_FFFF, MEM_FETCH, 8'h00, 32'h0, 32'd1));
        plan.push_back(row(word_of(CMD_STORE, 8'h01, 32'hFFFF_FFFF, 2'd2, 1'b0, '0),
                           1'b1, ST_DONE, 32'h0, MEM_NONE, 8'h00, 32'h0, 32'd1));
        plan.push_back(row(word_of(CMD_LOAD, 8'h01, 32'h0, 2'd3, 1'b0, '0),
                           1'b1, ST_DONE, 32'hFFFF_FFFF, MEM_NONE, 8'h00, 32'h0, 32'd1));
        plan.push_back(row(word_of(CMD_LOAD, 8'hC2, 32'h0, 2'd0, 1'b1,
                                   {32'h8000_0000, 32'h0, 32'h5A5A_5A5A, 32'hA5A5_A5A5})));
        plan.push_back(row(word_of(CMD_STORE, 8'hFF, 32'h0, 2'd1, 1'b0, '1),
                           1'b1, ST_RETRY, 32'h0, MEM_WRITE, 8'hFF, 32'h0, 32'd2));
        plan.push_back(row(word_of(CMD_STORE, 8'h80, 32'hDEAD_BEEF, 2'd2, 1'b1, '0),
                           1'b1, ST_RETRY, 32'h0, MEM_NONE, 8'h00, 32'h0, 32'd2));
        plan.push_back(row(word_of(CMD_STORE, 8'hFF, 32'h8000_0001, 2'd1, 1'b1, '0),
                           1'b1, ST_DONE, 32'h0, MEM_WRITE, 8'hFF, 32'h8000_0001, 32'd2));
        plan.push_back(row(word_of(CMD_NOP, 8'hFF, 32'hFFFF_FFFF, 2'd3, 1'b1, '1),
                           1'b1, ST_DONE, 32'h0, MEM_NONE, 8'h00, 32'h0, 32'd2));
        plan.push_back(row(word_of(CMD_LOAD, 8'h10, 32'h0, 2'd2, 1'b0, '0),
                           1'b1, ST_RETRY, 32'h0, MEM_FETCH, 8'h10, 32'h0, 32'd2));
        plan.push_back(row(word_of(CMD_INVAL, 8'h55, 32'h1234_5678, 2'd1, 1'b1, '0),
                           1'b1, ST_DONE, 32'h0, MEM_NONE, 8'h00, 32'h0, 32'd2));
        plan.push_back(row(word_of(CMD_LOAD, 8'h11, 32'h0, 2'd0, 1'b1, '0),
                           1'b1, ST_RETRY, 32'h0, MEM_NONE, 8'h00, 32'h0, 32'd2));
        plan.push_back(row(word_of(CMD_LOAD, 8'h12, 32'h0, 2'd2, 1'b1,
                                   {32'h4444_4444, 32'h3333_3333, 32'hCAFE_0001, 32'h0BAD_F00D})));
        plan.push_back(row(word_of(CMD_LOAD, 8'hC1, 32'h0, 2'd0, 1'b1,
                                   {32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_FFFF, 32'h0000_0001})));
        plan.push_back(row(word_of(CMD_STORE, 8'hC3, 32'h1234_5678, 2'd0, 1'b0, '0)));
        plan.push_back(row(word_of(CMD_STORE, 8'hC0, 32'h0, 2'd0, 1'b0, '0)));
        plan.push_back(row(word_of(CMD_LOAD, 8'h3C, 32'h0, 2'd3, 1'b1,
                                   {32'h6666_6666, 32'h5555_5555, 32'h7777_7777, 32'h8888_8888})));
        plan.push_back(row(word_of(CMD_LOAD, 8'h02, 32'h0, 2'd1, 1'b1,
                                   {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF})));
        plan.push_back(row(word_of(CMD_LOAD, 8'hFC, 32'h0, 2'd2, 1'b1,
                                   {32'h9999_9999, 32'hAAAA_AAAA, 32'hBBBB_BBBB, 32'hCCCC_CCCC})));
        plan.push_back(row(word_of(CMD_STORE, 8'h3F, 32'h0000_FFFF, 2'd2, 1'b0, '0)));
        plan.push_back(row(word_of(CMD_STORE, 8'h3F, 32'hFFFF_0000, 2'd2, 1'b1, '0)));
        foreach (plan[i])
            send_word(plan[i].w, plan[i].typed, plan[i].want);

        for (int p = 0; p < 6; p++)
        begin
            write_delay(DELAY_W'(phase_delay[p]));
            if (p == 5)
                steady = 1'b1;
            run_phase(phase_words[p]);
        end

        drain();
        $display("sent %0d request words under access delays 0, 1, 2, 17 and 255", words_sent);
        $display("checked %0d results: %0d line fills, %0d dirty lines written back",
                 results_seen, fill_total, victims_seen);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
